[rtl/rrsps_pkg.sv]
// Shared types and constants of the round-robin stream packet scheduler.
`timescale 1ns / 1ps
package rrsps_pkg;

  // Operation codes of an input transaction.
  localparam logic [1:0] FUNC_PUSH    = 2'd0;
  localparam logic [1:0] FUNC_POP     = 2'd1;
  localparam logic [1:0] FUNC_ADVANCE = 2'd2;
  localparam logic [1:0] FUNC_NOP     = 2'd3;

  // Result error codes.
  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_POP_EMPTY   = 2'd1;
  localparam logic [1:0] ERR_TABLE_FULL  = 2'd2;
  localparam logic [1:0] ERR_QUEUE_FULL  = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 40;
  localparam logic [CFG_IDX_W-1:0] REG_LEADING_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME    = 1'b1;

  localparam logic [15:0] RESET_LEADING_LIMIT = 16'd1400;

  localparam int unsigned IN_TDATA_W  = 144;
  localparam int unsigned OUT_TDATA_W = 136;

  // One packet slot as it sits in the slot memory.
  typedef struct packed {
    logic        valid;
    logic [3:0]  prio;
    logic [31:0] order;
    logic [39:0] ts;
    logic [11:0] handle;
    logic [15:0] nbytes;
  } slot_word_t;

endpackage

[rtl/rrsps_ram.sv]
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module rrsps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[rtl/rrsps_alu.sv]
// Shared 64-bit adder/subtractor used for accumulation, time debit and division.
`timescale 1ns / 1ps
module rrsps_alu (
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic        sub_i,
  output logic [63:0] res_o,
  output logic        carry_o
);

  logic [64:0] full;

  // On subtraction the carry out is set when a is not below b.
  assign full    = {1'b0, a_i} + {1'b0, (sub_i ? ~b_i : b_i)} + {64'd0, sub_i};
  assign res_o   = full[63:0];
  assign carry_o = full[64];

endmodule

[rtl/round_robin_stream_packet_scheduler.sv]
// A push or pop scans the stream table and then the chosen stream's slots; the 64-step divider
// for the average follows every transaction and is skipped when nothing is queued or the wait
// sum is negative. One transaction is in work at a time, so a new one is taken only when the
// last is through. The multiply, the pop's time debit and the divide all share one adder.
// After reset the slot memory is swept, one entry a cycle, over all MAX_STREAMS * QUEUE_DEPTH
// entries before the first transaction is taken; configuration writes are taken at all times.
`timescale 1ns / 1ps
module round_robin_stream_packet_scheduler #(
  parameter int unsigned MAX_STREAMS = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rrsps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rrsps_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // func, stream_ssrc, priority_req, push sequence number, time_us, packet_bytes,
  // packet_handle, zero pad
  input  logic [rrsps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pop_valid, error_code, out_ssrc, out_handle, out_bytes, queued_packets,
  // queued_bytes, avg_queue_time_us, is_empty, zero pad
  output logic [rrsps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import rrsps_pkg::*;

  localparam int TOTAL = MAX_STREAMS * QUEUE_DEPTH;
  localparam int SW    = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int KW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int CW    = $clog2(TOTAL + 1);
  localparam int CXW   = (CW > 8) ? CW : 8;
  localparam int BW0   = $clog2(TOTAL * 65535 + 1);
  localparam int BW    = (BW0 > 23) ? BW0 : 23;
  localparam int WW    = $bits(slot_word_t);

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_STR      = 4'd2;
  localparam logic [3:0] ST_STR_END  = 4'd3;
  localparam logic [3:0] ST_SLOT     = 4'd4;
  localparam logic [3:0] ST_SLOT_END = 4'd5;
  localparam logic [3:0] ST_TIME     = 4'd6;
  localparam logic [3:0] ST_MUL      = 4'd7;
  localparam logic [3:0] ST_PUSH_UPD = 4'd8;
  localparam logic [3:0] ST_POP_A    = 4'd9;
  localparam logic [3:0] ST_POP_B    = 4'd10;
  localparam logic [3:0] ST_DIV_INIT = 4'd11;
  localparam logic [3:0] ST_DIV      = 4'd12;
  localparam logic [3:0] ST_OUT      = 4'd13;

  // Control state.
  logic [3:0]     state_q, state_d;
  logic [SW-1:0]  sidx_q, sidx_d, sel_q, sel_d;
  logic [KW-1:0]  iss_q, iss_d, dk_q, dk_d;
  logic           iss_done_q, iss_done_d, dv_q, dv_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic           found_q, found_d, free_q, free_d;
  logic           b1_found_q, b1_found_d, b2_found_q, b2_found_d;
  logic [5:0]     divc_q, divc_d;
  logic           out_valid_q, out_valid_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [BW-1:0]  bcnt_q, bcnt_d;
  logic [63:0]    sum_q, sum_d;
  logic [39:0]    last_q, last_d;
  logic [47:0]    maxs_q, maxs_d;
  logic [15:0]    limit_q, limit_d;

  // Stream table.
  logic [MAX_STREAMS-1:0] inuse_q, inuse_d, active_q, active_d;
  logic [47:0]            sent_q [MAX_STREAMS];
  logic [47:0]            sent_d [MAX_STREAMS];
  logic [31:0]            id_q   [MAX_STREAMS];
  logic [31:0]            id_d   [MAX_STREAMS];
  logic [3:0]             key_q  [MAX_STREAMS];
  logic [3:0]             key_d  [MAX_STREAMS];

  // Transaction payload and working registers.
  logic [1:0]     func_q, func_d;
  logic [31:0]    ssrc_q, ssrc_d;
  logic [3:0]     prio_q, prio_d;
  logic [31:0]    order_q, order_d;
  logic [39:0]    time_q, time_d;
  logic [15:0]    pbytes_q, pbytes_d;
  logic [11:0]    handle_q, handle_d;
  logic           sel_inuse_q, sel_inuse_d, sel_active_q, sel_active_d;
  logic [3:0]     bkey_q, bkey_d;
  logic [47:0]    bsent_q, bsent_d;
  logic [31:0]    bid_q, bid_d;
  logic [35:0]    b1_key_q, b1_key_d, b2_key_q, b2_key_d;
  slot_word_t     b1_word_q, b1_word_d;
  logic [KW-1:0]  b1_k_q, b1_k_d, free_k_q, free_k_d;
  logic [63:0]    delta_q, delta_d, mcand_q, mcand_d, dvd_q, dvd_d;
  logic [CW-1:0]  mplier_q, mplier_d, rem_q, rem_d;
  logic [47:0]    satsum_q, satsum_d, floor_q, floor_d;
  logic           o_pop_q, o_pop_d;
  logic [1:0]     o_err_q, o_err_d;
  logic [31:0]    o_ssrc_q, o_ssrc_d;
  logic [11:0]    o_handle_q, o_handle_d;
  logic [15:0]    o_bytes_q, o_bytes_d;
  logic [OUT_TDATA_W-1:0] out_tdata_q, out_tdata_d;

  // Slot memory and shared adder.
  logic           ram_we;
  logic [AW-1:0]  ram_addr, slot_base;
  slot_word_t     ram_wdata, rd;
  logic [WW-1:0]  ram_rdata;
  logic [63:0]    alu_a, alu_b, alu_res;
  logic           alu_sub, alu_carry;

  logic           s_acc;
  logic [35:0]    rd_key;
  logic [40:0]    diff41;
  logic [48:0]    sum49;
  logic [47:0]    new_sent;
  logic [CW:0]    remsh;
  logic [CXW-1:0] cnt_x;

  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign slot_base = AW'(AW'(sel_q) * AW'(QUEUE_DEPTH));
  assign rd        = slot_word_t'(ram_rdata);
  assign rd_key    = {rd.prio, rd.order};
  assign remsh     = {rem_q, dvd_q[63]};
  assign new_sent  = (satsum_q > floor_q) ? satsum_q : floor_q;
  assign cnt_x     = CXW'(cnt_q);

  rrsps_ram #(
    .WIDTH (WW),
    .DEPTH (TOTAL)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  rrsps_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  always_comb begin
    state_d      = state_q;
    sidx_d       = sidx_q;
    sel_d        = sel_q;
    iss_d        = iss_q;
    dk_d         = dk_q;
    iss_done_d   = iss_done_q;
    dv_d         = 1'b0;
    clr_d        = clr_q;
    found_d      = found_q;
    free_d       = free_q;
    b1_found_d   = b1_found_q;
    b2_found_d   = b2_found_q;
    divc_d       = divc_q;
    out_valid_d  = out_valid_q;
    cnt_d        = cnt_q;
    bcnt_d       = bcnt_q;
    sum_d        = sum_q;
    last_d       = last_q;
    maxs_d       = maxs_q;
    limit_d      = limit_q;
    inuse_d      = inuse_q;
    active_d     = active_q;
    sent_d       = sent_q;
    id_d         = id_q;
    key_d        = key_q;
    func_d       = func_q;
    ssrc_d       = ssrc_q;
    prio_d       = prio_q;
    order_d      = order_q;
    time_d       = time_q;
    pbytes_d     = pbytes_q;
    handle_d     = handle_q;
    sel_inuse_d  = sel_inuse_q;
    sel_active_d = sel_active_q;
    bkey_d       = bkey_q;
    bsent_d      = bsent_q;
    bid_d        = bid_q;
    b1_key_d     = b1_key_q;
    b2_key_d     = b2_key_q;
    b1_word_d    = b1_word_q;
    b1_k_d       = b1_k_q;
    free_k_d     = free_k_q;
    delta_d      = delta_q;
    mcand_d      = mcand_q;
    mplier_d     = mplier_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    satsum_d     = satsum_q;
    floor_d      = floor_q;
    o_pop_d      = o_pop_q;
    o_err_d      = o_err_q;
    o_ssrc_d     = o_ssrc_q;
    o_handle_d   = o_handle_q;
    o_bytes_d    = o_bytes_q;
    out_tdata_d  = out_tdata_q;
    ram_we       = 1'b0;
    ram_addr     = slot_base + AW'(iss_q);
    ram_wdata    = b1_word_q;
    alu_a        = sum_q;
    alu_b        = mcand_q;
    alu_sub      = 1'b0;
    diff41       = {1'b0, time_q} - {1'b0, last_q};
    sum49        = {1'b0, bsent_q} + {33'd0, b1_word_q.nbytes};
    s_axis_tready = (state_q == ST_IDLE);

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(TOTAL - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_acc) begin
          func_d     = s_axis_tdata[1:0];
          ssrc_d     = s_axis_tdata[33:2];
          prio_d     = s_axis_tdata[37:34];
          order_d    = s_axis_tdata[69:38];
          time_d     = s_axis_tdata[109:70];
          pbytes_d   = s_axis_tdata[125:110];
          handle_d   = s_axis_tdata[137:126];
          o_pop_d    = 1'b0;
          o_err_d    = ERR_NONE;
          o_ssrc_d   = '0;
          o_handle_d = '0;
          o_bytes_d  = '0;
          sidx_d     = '0;
          found_d    = 1'b0;
          free_d     = 1'b0;
          unique case (s_axis_tdata[1:0])
            FUNC_PUSH, FUNC_POP: state_d = ST_STR;
            FUNC_ADVANCE:        state_d = ST_TIME;
            default:             state_d = ST_DIV_INIT;
          endcase
        end
      end
      ST_STR: begin
        if (func_q == FUNC_PUSH) begin
          if (!found_q) begin
            if (inuse_q[sidx_q] && id_q[sidx_q] == ssrc_q) begin
              found_d      = 1'b1;
              sel_d        = sidx_q;
              sel_active_d = active_q[sidx_q];
              bkey_d       = key_q[sidx_q];
            end else if (!inuse_q[sidx_q] && !free_q) begin
              free_d = 1'b1;
              sel_d  = sidx_q;
            end
          end
        end else if (active_q[sidx_q] &&
                     (!found_q || key_q[sidx_q] < bkey_q ||
                      (key_q[sidx_q] == bkey_q && sent_q[sidx_q] < bsent_q))) begin
          found_d = 1'b1;
          sel_d   = sidx_q;
          bkey_d  = key_q[sidx_q];
          bsent_d = sent_q[sidx_q];
          bid_d   = id_q[sidx_q];
        end
        if (sidx_q == SW'(MAX_STREAMS - 1)) begin
          state_d = ST_STR_END;
        end else begin
          sidx_d = sidx_q + SW'(1);
        end
      end
      ST_STR_END: begin
        iss_d      = '0;
        iss_done_d = 1'b0;
        b1_found_d = 1'b0;
        b2_found_d = 1'b0;
        free_d     = 1'b0;
        if (func_q == FUNC_PUSH) begin
          sel_inuse_d = found_q;
          if (!found_q) begin
            sel_active_d = 1'b0;
          end
          if (found_q || free_q) begin
            state_d = ST_SLOT;
          end else begin
            o_err_d = ERR_TABLE_FULL;
            state_d = ST_DIV_INIT;
          end
        end else if (found_q) begin
          state_d = ST_SLOT;
        end else begin
          o_err_d = ERR_POP_EMPTY;
          state_d = ST_DIV_INIT;
        end
      end
      ST_SLOT: begin
        // Reads are issued one a cycle; data of the previous issue is checked here.
        if (!iss_done_q) begin
          dv_d = 1'b1;
          dk_d = iss_q;
          if (iss_q == KW'(QUEUE_DEPTH - 1)) begin
            iss_done_d = 1'b1;
          end else begin
            iss_d = iss_q + KW'(1);
          end
        end
        if (dv_q) begin
          if (func_q == FUNC_PUSH) begin
            if (!rd.valid && !free_q) begin
              free_d   = 1'b1;
              free_k_d = dk_q;
            end
          end else if (rd.valid) begin
            if (!b1_found_q || rd_key < b1_key_q) begin
              b2_found_d = b1_found_q;
              b2_key_d   = b1_key_q;
              b1_found_d = 1'b1;
              b1_key_d   = rd_key;
              b1_word_d  = rd;
              b1_k_d     = dk_q;
            end else if (!b2_found_q || rd_key < b2_key_q) begin
              b2_found_d = 1'b1;
              b2_key_d   = rd_key;
            end
          end
          if (dk_q == KW'(QUEUE_DEPTH - 1)) begin
            state_d = ST_SLOT_END;
          end
        end
      end
      ST_SLOT_END: begin
        if (func_q == FUNC_PUSH) begin
          if (free_q) begin
            state_d = ST_TIME;
          end else begin
            o_err_d = ERR_QUEUE_FULL;
            state_d = ST_DIV_INIT;
          end
        end else if (b1_found_q) begin
          state_d = ST_POP_A;
        end else begin
          active_d[sel_q] = 1'b0;
          o_err_d         = ERR_POP_EMPTY;
          state_d         = ST_DIV_INIT;
        end
      end
      ST_TIME: begin
        delta_d  = {{23{diff41[40]}}, diff41};
        mcand_d  = {{23{diff41[40]}}, diff41};
        mplier_d = cnt_q;
        last_d   = time_q;
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        // Shift-and-add of the time step times the packet count into the sum.
        if (mplier_q == '0) begin
          state_d = (func_q == FUNC_PUSH) ? ST_PUSH_UPD : ST_DIV_INIT;
        end else begin
          if (mplier_q[0]) begin
            sum_d = alu_res;
          end
          mcand_d  = {mcand_q[62:0], 1'b0};
          mplier_d = mplier_q >> 1;
        end
      end
      ST_PUSH_UPD: begin
        if (!sel_inuse_q) begin
          inuse_d[sel_q] = 1'b1;
          id_d[sel_q]    = ssrc_q;
          sent_d[sel_q]  = '0;
        end
        if (!sel_inuse_q || !sel_active_q) begin
          active_d[sel_q] = 1'b1;
          key_d[sel_q]    = prio_q;
        end else if (prio_q < bkey_q) begin
          key_d[sel_q] = prio_q;
        end
        cnt_d            = cnt_q + CW'(1);
        bcnt_d           = bcnt_q + BW'(pbytes_q);
        ram_we           = 1'b1;
        ram_addr         = slot_base + AW'(free_k_q);
        ram_wdata.valid  = 1'b1;
        ram_wdata.prio   = prio_q;
        ram_wdata.order  = order_q;
        ram_wdata.ts     = time_q;
        ram_wdata.handle = handle_q;
        ram_wdata.nbytes = pbytes_q;
        state_d          = ST_DIV_INIT;
      end
      ST_POP_A: begin
        diff41   = {1'b0, last_q} - {1'b0, b1_word_q.ts};
        delta_d  = {{23{diff41[40]}}, diff41};
        satsum_d = sum49[48] ? '1 : sum49[47:0];
        floor_d  = (maxs_q > {32'd0, limit_q}) ? maxs_q - {32'd0, limit_q} : '0;
        ram_we   = 1'b1;
        ram_addr = slot_base + AW'(b1_k_q);
        ram_wdata.valid = 1'b0;
        cnt_d    = cnt_q - CW'(1);
        bcnt_d   = bcnt_q - BW'(b1_word_q.nbytes);
        if (b2_found_q) begin
          key_d[sel_q] = b2_key_q[35:32];
        end else begin
          active_d[sel_q] = 1'b0;
        end
        o_pop_d    = 1'b1;
        o_ssrc_d   = bid_q;
        o_handle_d = b1_word_q.handle;
        o_bytes_d  = b1_word_q.nbytes;
        state_d    = ST_POP_B;
      end
      ST_POP_B: begin
        alu_b         = delta_q;
        alu_sub       = 1'b1;
        sum_d         = alu_res;
        sent_d[sel_q] = new_sent;
        if (new_sent > maxs_q) begin
          maxs_d = new_sent;
        end
        state_d = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        rem_d  = '0;
        divc_d = '0;
        if (cnt_q == '0 || sum_q[63]) begin
          dvd_d   = '0;
          state_d = ST_OUT;
        end else begin
          dvd_d   = sum_q;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit a cycle; quotient shifts into dvd.
        alu_a   = 64'(remsh);
        alu_b   = 64'(cnt_q);
        alu_sub = 1'b1;
        rem_d   = alu_carry ? alu_res[CW-1:0] : remsh[CW-1:0];
        dvd_d   = {dvd_q[62:0], alu_carry};
        divc_d  = divc_q + 6'd1;
        if (divc_q == 6'd63) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_tdata_d = {1'b0, (cnt_q == '0),
                         ((|dvd_q[63:40]) ? 40'hFF_FFFF_FFFF : dvd_q[39:0]),
                         bcnt_q[22:0], cnt_x[7:0], o_bytes_q, o_handle_q,
                         o_ssrc_q, o_err_q, o_pop_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEADING_LIMIT: begin
          limit_d = cfg_wdata_i[15:0];
          maxs_d  = {32'd0, cfg_wdata_i[15:0]};
        end
        REG_START_TIME: begin
          last_d = cfg_wdata_i[39:0];
        end
        default: begin
          limit_d = limit_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sidx_q      <= '0;
      sel_q       <= '0;
      iss_q       <= '0;
      dk_q        <= '0;
      iss_done_q  <= 1'b0;
      dv_q        <= 1'b0;
      clr_q       <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      b1_found_q  <= 1'b0;
      b2_found_q  <= 1'b0;
      divc_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      bcnt_q      <= '0;
      sum_q       <= '0;
      last_q      <= '0;
      maxs_q      <= {32'd0, RESET_LEADING_LIMIT};
      limit_q     <= RESET_LEADING_LIMIT;
      inuse_q     <= '0;
      active_q    <= '0;
      for (int i = 0; i < MAX_STREAMS; i++) begin
        sent_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      sidx_q      <= sidx_d;
      sel_q       <= sel_d;
      iss_q       <= iss_d;
      dk_q        <= dk_d;
      iss_done_q  <= iss_done_d;
      dv_q        <= dv_d;
      clr_q       <= clr_d;
      found_q     <= found_d;
      free_q      <= free_d;
      b1_found_q  <= b1_found_d;
      b2_found_q  <= b2_found_d;
      divc_q      <= divc_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      bcnt_q      <= bcnt_d;
      sum_q       <= sum_d;
      last_q      <= last_d;
      maxs_q      <= maxs_d;
      limit_q     <= limit_d;
      inuse_q     <= inuse_d;
      active_q    <= active_d;
      sent_q      <= sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q         <= id_d;
    key_q        <= key_d;
    func_q       <= func_d;
    ssrc_q       <= ssrc_d;
    prio_q       <= prio_d;
    order_q      <= order_d;
    time_q       <= time_d;
    pbytes_q     <= pbytes_d;
    handle_q     <= handle_d;
    sel_inuse_q  <= sel_inuse_d;
    sel_active_q <= sel_active_d;
    bkey_q       <= bkey_d;
    bsent_q      <= bsent_d;
    bid_q        <= bid_d;
    b1_key_q     <= b1_key_d;
    b2_key_q     <= b2_key_d;
    b1_word_q    <= b1_word_d;
    b1_k_q       <= b1_k_d;
    free_k_q     <= free_k_d;
    delta_q      <= delta_d;
    mcand_q      <= mcand_d;
    mplier_q     <= mplier_d;
    dvd_q        <= dvd_d;
    rem_q        <= rem_d;
    satsum_q     <= satsum_d;
    floor_q      <= floor_d;
    o_pop_q      <= o_pop_d;
    o_err_q      <= o_err_d;
    o_ssrc_q     <= o_ssrc_d;
    o_handle_q   <= o_handle_d;
    o_bytes_q    <= o_bytes_d;
    out_tdata_q  <= out_tdata_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TOTAL))
    else $error("packet count exceeds slot capacity");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("second transaction taken while one is in work");

  a_pop_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && o_pop_q) |-> (o_err_q == ERR_NONE))
    else $error("dequeued packet reported together with an error");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!s_axis_tready && !out_valid_q))
    else $error("transaction traffic during the memory sweep");

  a_empty_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && cnt_q == '0) |-> (active_q == '0))
    else $error("stream left active with no packet queued");
`endif

endmodule

[tb/sv/tb_round_robin_stream_packet_scheduler.sv]
// Self-checking testbench of the round-robin stream packet scheduler.
`timescale 1ns / 1ps
module tb_round_robin_stream_packet_scheduler;
  import rrsps_pkg::*;

  localparam int unsigned NSTREAM  = 8;
  localparam int unsigned NDEPTH   = 16;
  localparam int unsigned NSLOT    = NSTREAM * NDEPTH;
  localparam int unsigned HOLD_LEN = 400;
  localparam int unsigned WD_LIMIT = 3000;
  localparam int unsigned SETTLE   = 300;

  typedef struct packed {
    logic [5:0]  pad;
    logic [11:0] handle;
    logic [15:0] nbytes;
    logic [39:0] now_us;
    logic [31:0] order;
    logic [3:0]  prio;
    logic [31:0] ssrc;
    logic [1:0]  func;
  } cmd_t;

  typedef struct packed {
    logic        pad;
    logic        is_empty;
    logic [39:0] avg_us;
    logic [22:0] qbytes;
    logic [7:0]  qpkts;
    logic [15:0] nbytes;
    logic [11:0] handle;
    logic [31:0] ssrc;
    logic [1:0]  err;
    logic        popped;
  } status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  round_robin_stream_packet_scheduler i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Scheduler state mirrored by the predictor.
  logic [31:0] sched_id [NSTREAM];
  bit          sched_used [NSTREAM];
  logic [47:0] sched_sent [NSTREAM];
  logic [3:0]  sched_key [NSTREAM];
  bit          sched_act [NSTREAM];
  logic [35:0] slot_key [NSLOT];
  logic [39:0] slot_ts [NSLOT];
  logic [11:0] slot_hdl [NSLOT];
  logic [15:0] slot_len [NSLOT];
  bit          slot_busy [NSLOT];
  logic [47:0] max_sent;
  logic [63:0] wait_sum;
  logic [39:0] last_ts;
  logic [15:0] lead_limit;
  int unsigned pkt_cnt, byte_cnt;

  cmd_t    pending_cmds [$];
  status_t expected_status [$];
  cmd_t    gen;
  bit      failed = 1'b0;
  bit      quiet = 1'b0;
  bit      hold_req = 1'b0;
  logic [31:0] ssrc_pool [NSTREAM];
  logic [39:0] clock_us;

  function automatic void clock_wait(logic [39:0] t);
    logic [63:0] delta;
    delta = {24'd0, t} - {24'd0, last_ts};
    wait_sum = wait_sum + delta * 64'(pkt_cnt);
    last_ts = t;
  endfunction

  function automatic int lowest_slot(int s);
    int b;
    b = -1;
    for (int k = 0; k < NDEPTH; k++) begin
      if (slot_busy[s*NDEPTH+k] && (b < 0 || slot_key[s*NDEPTH+k] < slot_key[b]))
        b = s * NDEPTH + k;
    end
    return b;
  endfunction

  function automatic logic [1:0] enqueue_packet(cmd_t c);
    int f, fr, sl;
    f = -1; fr = -1; sl = -1;
    for (int s = 0; s < NSTREAM; s++) begin
      if (sched_used[s] && sched_id[s] == c.ssrc) begin
        f = s;
        break;
      end
      if (!sched_used[s] && fr < 0) fr = s;
    end
    if (f < 0) begin
      if (fr < 0) return ERR_TABLE_FULL;
      f = fr;
    end
    for (int k = 0; k < NDEPTH; k++) begin
      if (!slot_busy[f*NDEPTH+k]) begin
        sl = f * NDEPTH + k;
        break;
      end
    end
    if (sl < 0) return ERR_QUEUE_FULL;
    if (!sched_used[f]) begin
      sched_used[f] = 1'b1;
      sched_id[f] = c.ssrc;
      sched_sent[f] = '0;
      sched_act[f] = 1'b0;
    end
    if (!sched_act[f]) begin
      sched_act[f] = 1'b1;
      sched_key[f] = c.prio;
    end else if (c.prio < sched_key[f]) begin
      sched_key[f] = c.prio;
    end
    clock_wait(c.now_us);
    pkt_cnt++;
    byte_cnt += 32'(c.nbytes);
    slot_key[sl] = {c.prio, c.order};
    slot_ts[sl] = c.now_us;
    slot_hdl[sl] = c.handle;
    slot_len[sl] = c.nbytes;
    slot_busy[sl] = 1'b1;
    return ERR_NONE;
  endfunction

  function automatic status_t schedule_step(cmd_t c);
    status_t r;
    int b, sl, nx;
    logic [48:0] acc;
    logic [47:0] flo;
    logic [63:0] q;
    r = '0;
    if (c.func == FUNC_PUSH) begin
      r.err = enqueue_packet(c);
    end else if (c.func == FUNC_POP) begin
      b = -1;
      for (int s = 0; s < NSTREAM; s++) begin
        if (!sched_act[s]) continue;
        if (b < 0 || sched_key[s] < sched_key[b] ||
            (sched_key[s] == sched_key[b] && sched_sent[s] < sched_sent[b]))
          b = s;
      end
      sl = (b < 0) ? -1 : lowest_slot(b);
      if (b < 0) begin
        r.err = ERR_POP_EMPTY;
      end else if (sl < 0) begin
        sched_act[b] = 1'b0;
        r.err = ERR_POP_EMPTY;
      end else begin
        wait_sum = wait_sum - ({24'd0, last_ts} - {24'd0, slot_ts[sl]});
        acc = {1'b0, sched_sent[b]} + 49'(slot_len[sl]);
        if (acc[48]) acc = {1'b0, {48{1'b1}}};
        flo = (max_sent > 48'(lead_limit)) ? max_sent - 48'(lead_limit) : '0;
        sched_sent[b] = (acc[47:0] > flo) ? acc[47:0] : flo;
        if (sched_sent[b] > max_sent) max_sent = sched_sent[b];
        slot_busy[sl] = 1'b0;
        pkt_cnt--;
        byte_cnt -= 32'(slot_len[sl]);
        nx = lowest_slot(b);
        if (nx < 0) sched_act[b] = 1'b0;
        else sched_key[b] = slot_key[nx][35:32];
        r.popped = 1'b1;
        r.ssrc = sched_id[b];
        r.handle = slot_hdl[sl];
        r.nbytes = slot_len[sl];
      end
    end else if (c.func == FUNC_ADVANCE) begin
      clock_wait(c.now_us);
    end
    r.qpkts = pkt_cnt[7:0];
    r.qbytes = byte_cnt[22:0];
    if (pkt_cnt != 0 && !wait_sum[63]) begin
      q = wait_sum / 64'(pkt_cnt);
      r.avg_us = (q > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : q[39:0];
    end
    r.is_empty = (pkt_cnt == 0);
    return r;
  endfunction

  // Sender: offers queued commands with random gaps.
  int unsigned src_gap = 0;
  always @(posedge clk_i) begin
    bit   take;
    logic nv;
    take = s_axis_tvalid && s_axis_tready;
    nv = s_axis_tvalid;
    if (take) begin
      expected_status.push_back(schedule_step(cmd_t'(s_axis_tdata)));
      void'(pending_cmds.pop_front());
    end
    if (!s_axis_tvalid || take) begin
      nv = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(0, 3);
      end else if (pending_cmds.size() > 0) begin
        nv = 1'b1;
        s_axis_tdata <= pending_cmds[0];
      end
    end
    s_axis_tvalid <= nv;
  end

  // Receiver: random stalls plus one long hold-off on request.
  int unsigned sink_stall = 0;
  int unsigned hold_cnt = 0;
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      sink_stall = $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, e, a);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin
    status_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = status_t'(m_axis_tdata);
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected result, actual %0h", $realtime, m_axis_tdata);
        failed = 1'b1;
      end else begin
        want = expected_status.pop_front();
        check_field("pop_valid", 64'(want.popped), 64'(got.popped));
        check_field("error_code", 64'(want.err), 64'(got.err));
        check_field("out_ssrc", 64'(want.ssrc), 64'(got.ssrc));
        check_field("out_handle", 64'(want.handle), 64'(got.handle));
        check_field("out_bytes", 64'(want.nbytes), 64'(got.nbytes));
        check_field("queued_packets", 64'(want.qpkts), 64'(got.qpkts));
        check_field("queued_bytes", 64'(want.qbytes), 64'(got.qbytes));
        check_field("avg_queue_time_us", 64'(want.avg_us), 64'(got.avg_us));
        check_field("is_empty", 64'(want.is_empty), 64'(got.is_empty));
      end
    end
  end

  // Watchdog on cycles without any accepted transaction while work is open.
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_cmds.size() == 0 && expected_status.size() == 0)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= WD_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic cmd_t make_cmd(logic [1:0] f, logic [31:0] id, logic [3:0] p);
    cmd_t c;
    c = '0;
    c.func = f;
    c.ssrc = id;
    c.prio = p;
    c.order = $urandom;
    c.now_us = clock_us;
    c.nbytes = 16'($urandom_range(0, 65535));
    c.handle = 12'($urandom_range(0, 4095));
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    int unsigned pick;
    logic [1:0] f;
    pick = $urandom_range(0, 99);
    f = (pick < 46) ? FUNC_PUSH : (pick < 86) ? FUNC_POP :
        (pick < 95) ? FUNC_ADVANCE : FUNC_NOP;
    pick = $urandom_range(0, 99);
    if (pick < 3) clock_us = clock_us - 40'($urandom_range(0, 5000));
    else if (pick < 4) clock_us = 40'({$urandom, $urandom});
    else clock_us = clock_us + 40'($urandom_range(0, 2000));
    return make_cmd(f, ($urandom_range(0, 9) == 0) ? $urandom :
                    ssrc_pool[3'($urandom_range(0, 7))], 4'($urandom_range(0, 15)));
  endfunction

  task automatic drain_and_settle();
    while (pending_cmds.size() > 0 || expected_status.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_LEADING_LIMIT) begin
      lead_limit = val[15:0];
      max_sent = 48'(val[15:0]);
    end else begin
      last_ts = val[39:0];
      clock_us = val[39:0];
    end
  endtask

  initial begin
    logic [15:0] limits [4];
    logic [39:0] starts [4];
    for (int s = 0; s < NSTREAM; s++) begin
      sched_used[s] = 1'b0; sched_act[s] = 1'b0; sched_sent[s] = '0;
      sched_id[s] = '0; sched_key[s] = '0;
    end
    for (int i = 0; i < NSLOT; i++) slot_busy[i] = 1'b0;
    lead_limit = RESET_LEADING_LIMIT;
    max_sent = 48'(RESET_LEADING_LIMIT);
    wait_sum = '0; last_ts = '0; pkt_cnt = 0; byte_cnt = 0; clock_us = '0;
    ssrc_pool[0] = 32'd0;
    ssrc_pool[1] = 32'hFFFF_FFFF;
    for (int s = 2; s < NSTREAM; s++) ssrc_pool[s] = $urandom;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: pop on empty, advance, no-op, fill one stream past its depth,
    // open every other stream, then hit a full stream table.
    pending_cmds.push_back(make_cmd(FUNC_POP, '0, '0));
    clock_us = 40'd100;
    pending_cmds.push_back(make_cmd(FUNC_ADVANCE, '0, '0));
    pending_cmds.push_back(make_cmd(FUNC_NOP, '0, '0));
    for (int k = 0; k <= NDEPTH; k++) begin
      clock_us = clock_us + 40'd10;
      gen = make_cmd(FUNC_PUSH, ssrc_pool[0], (k % 2) ? 4'd15 : 4'd0);
      if (k == 1) begin
        gen.nbytes = 16'hFFFF; gen.handle = 12'hFFF; gen.order = 32'hFFFF_FFFF;
      end else if (k == 2) begin
        gen.nbytes = '0; gen.handle = '0; gen.order = '0;
      end
      pending_cmds.push_back(gen);
    end
    for (int s = 1; s < NSTREAM; s++)
      pending_cmds.push_back(make_cmd(FUNC_PUSH, ssrc_pool[s], 4'($urandom_range(0, 15))));
    gen = make_cmd(FUNC_PUSH, ~ssrc_pool[2], 4'd3);
    gen.now_us = 40'hFF_FFFF_FFFF;
    pending_cmds.push_back(gen);
    drain_and_settle();

    limits = '{16'd0, 16'hFFFF, 16'd1400, 16'($urandom)};
    starts = '{40'hFF_FFFF_FFFF, 40'd0, {8'($urandom), 32'($urandom)}, 40'd5000};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_LEADING_LIMIT, CFG_DATA_W'(limits[ph]));
      write_reg(REG_START_TIME, starts[ph]);
      if (ph == 3) quiet = 1'b1;
      if (ph == 1) hold_req = 1'b1;
      for (int n = 0; n < 245; n++) pending_cmds.push_back(random_cmd());
      drain_and_settle();
    end

    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[round_robin_stream_packet_scheduler.f]
rtl/rrsps_pkg.sv
rtl/rrsps_ram.sv
rtl/rrsps_alu.sv
rtl/round_robin_stream_packet_scheduler.sv
tb/sv/tb_round_robin_stream_packet_scheduler.sv
